### design/cts_pkg.sv
// Shared constants, codes and structs for the configuration token syntax checker.
package cts_pkg;

   // Sizing
   localparam int STACK_DEPTH = 16;
   localparam int MAX_COLUMNS = 256;
   localparam int MAX_ROWS    = 4096;

   localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
   localparam int STACK_IDX_W = $clog2(STACK_DEPTH);
   localparam int COLS_W      = $clog2(MAX_COLUMNS + 1);
   localparam int COL_IDX_W   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int ROW_CNT_W   = $clog2(MAX_ROWS + 2);
   localparam int ROWS_W      = $clog2(MAX_ROWS + 1);
   localparam int ROW_IDX_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

   localparam int KIND_W = 4;
   localparam int TAG_W  = 32;
   localparam int LINE_W = 24;
   localparam int COL_W  = 16;

   // Token kinds
   localparam logic [KIND_W-1:0] KIND_IDENT       = 4'd0;
   localparam logic [KIND_W-1:0] KIND_GROUP_OPEN  = 4'd1;
   localparam logic [KIND_W-1:0] KIND_TABLE_OPEN  = 4'd2;
   localparam logic [KIND_W-1:0] KIND_CLOSE       = 4'd3;
   localparam logic [KIND_W-1:0] KIND_STRING      = 4'd4;
   localparam logic [KIND_W-1:0] KIND_NUMBER      = 4'd5;
   localparam logic [KIND_W-1:0] KIND_ASSIGN      = 4'd6;
   localparam logic [KIND_W-1:0] KIND_NEWLINE     = 4'd7;
   localparam logic [KIND_W-1:0] KIND_END         = 4'd8;

   typedef enum logic [3:0] {
      ST_LINE_START    = 4'd1,
      ST_AFTER_NAME    = 4'd2,
      ST_AFTER_ASSIGN  = 4'd3,
      ST_PARAM_VALUES  = 4'd4,
      ST_TABLE_HEAD    = 4'd5,
      ST_ROW_START     = 4'd6,
      ST_ROW_VALUES    = 4'd7,
      ST_TABLE_CLOSED  = 4'd8,
      ST_GROUP_OPEN    = 4'd9,
      ST_GROUP_CLOSED  = 4'd10
   } state_type;

   typedef enum logic [2:0] {
      ACT_NONE       = 3'd0,
      ACT_STORED     = 3'd1,
      ACT_PARAM_DONE = 3'd2,
      ACT_TABLE_DONE = 3'd3,
      ACT_ERROR      = 3'd4,
      ACT_ACCEPT     = 3'd5
   } action_type;

   typedef enum logic [3:0] {
      ERR_NONE          = 4'd0,
      ERR_SCAN          = 4'd1,
      ERR_UNMATCHED     = 4'd2,
      ERR_MISMATCH      = 4'd3,
      ERR_BAD_TOKEN     = 4'd4,
      ERR_END_ASSIGN    = 4'd5,
      ERR_END_VALUE     = 4'd6,
      ERR_END_NEWLINE   = 4'd7,
      ERR_END_TABLE     = 4'd8,
      ERR_END_GROUP     = 4'd9,
      ERR_STACK_OVF     = 4'd10,
      ERR_TABLE_OVF     = 4'd11
   } err_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [TAG_W-1:0]  name_tag;
      logic [LINE_W-1:0] line;
      logic [COL_W-1:0]  col;
      logic              scan_fault;
   } token_type;

   typedef struct packed {
      state_type            state;
      logic [COLS_W-1:0]    next_column;
      logic [COLS_W-1:0]    column_total;
      logic [ROW_CNT_W-1:0] row_total;
      logic                 row_filled;
      logic                 fault_hold;
   } ctx_type;

   localparam ctx_type CTX_RESET = '{
      state:        ST_LINE_START,
      next_column:  '0,
      column_total: '0,
      row_total:    '0,
      row_filled:   1'b0,
      fault_hold:   1'b0
   };

   typedef struct packed {
      logic              push;
      logic              pop;
      logic              clear;
      logic [TAG_W-1:0]  name;
      logic [LINE_W-1:0] line;
      logic [COL_W-1:0]  col;
   } stack_op_type;

   typedef struct packed {
      logic [DEPTH_W-1:0] count;
      logic [TAG_W-1:0]   name;
      logic [LINE_W-1:0]  line;
      logic [COL_W-1:0]   col;
   } stack_view_type;

   typedef struct packed {
      action_type           action;
      err_type              err_code;
      logic [3:0]           err_state;
      logic [LINE_W-1:0]    err_line;
      logic [COL_W-1:0]     err_col;
      logic [LINE_W-1:0]    open_line;
      logic [COL_W-1:0]     open_col;
      logic [ROW_IDX_W-1:0] cell_row;
      logic [COL_IDX_W-1:0] cell_col;
      logic [ROWS_W-1:0]    item_rows;
      logic [COLS_W-1:0]    item_cols;
      logic [DEPTH_W-1:0]   nest_depth;
   } result_type;

endpackage

### design/cts_stack.sv
// Stack of open names with their source positions; top entry read combinationally.
module cts_stack import cts_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  stack_op_type   op,
   output stack_view_type view
);

   logic [DEPTH_W-1:0]     count_ff;
   logic [DEPTH_W-1:0]     count_in;
   logic [DEPTH_W-1:0]     top_count;
   logic [STACK_IDX_W-1:0] wr_idx;
   logic [STACK_IDX_W-1:0] top_idx;

   logic [TAG_W-1:0]  names_ff [STACK_DEPTH];
   logic [LINE_W-1:0] lines_ff [STACK_DEPTH];
   logic [COL_W-1:0]  cols_ff  [STACK_DEPTH];

   assign wr_idx    = count_ff[STACK_IDX_W-1:0];
   assign top_count = count_ff - DEPTH_W'(1);
   assign top_idx   = top_count[STACK_IDX_W-1:0];

   always_comb begin
      count_in = count_ff;
      if (op.clear) begin
         count_in = '0;
      end else if (op.push) begin
         count_in = count_ff + DEPTH_W'(1);
      end else if (op.pop) begin
         count_in = count_ff - DEPTH_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // push is only issued below full, so wr_idx stays in range
   always_ff @(posedge clock) begin
      if (op.push) begin
         names_ff[wr_idx] <= op.name;
         lines_ff[wr_idx] <= op.line;
         cols_ff[wr_idx]  <= op.col;
      end
   end

   // top is meaningless while the stack is empty; grammar checks count first
   assign view.count = count_ff;
   assign view.name  = names_ff[top_idx];
   assign view.line  = lines_ff[top_idx];
   assign view.col   = cols_ff[top_idx];

endmodule

### design/cts_grammar.sv
// One grammar step: next context, stack operation and result for one token.
module cts_grammar import cts_pkg::*; (
   input  token_type      tok,
   input  ctx_type        ctx,
   input  stack_view_type view,
   output ctx_type        ctx_in,
   output stack_op_type   op,
   output result_type     res
);

   logic              is_val;
   logic              stack_full;
   logic              stack_empty;
   logic              top_match;
   logic              raise;
   err_type           code;
   logic [LINE_W-1:0] oline;
   logic [COL_W-1:0]  ocol;
   logic              end_pop;
   logic [COLS_W-1:0] col_next;

   assign is_val      = (tok.kind == KIND_STRING) || (tok.kind == KIND_NUMBER);
   assign stack_full  = (view.count >= DEPTH_W'(STACK_DEPTH));
   assign stack_empty = (view.count == '0);
   assign top_match   = (view.name == tok.name_tag);
   assign col_next    = ctx.next_column + COLS_W'(1);

   always_comb begin
      ctx_in   = ctx;
      op       = '0;
      op.name  = tok.name_tag;
      op.line  = tok.line;
      op.col   = tok.col;
      res      = '0;
      raise    = 1'b0;
      code     = ERR_NONE;
      oline    = tok.line;
      ocol     = tok.col;
      end_pop  = 1'b0;

      if (tok.kind == KIND_END) begin
         if (!ctx.fault_hold) begin
            if (ctx.state == ST_PARAM_VALUES) begin
               end_pop       = !stack_empty;
               res.item_rows = ROWS_W'(1);
               res.item_cols = ctx.column_total;
            end
            case (ctx.state)
               ST_AFTER_NAME: begin
                  raise = 1'b1;
                  code  = ERR_END_ASSIGN;
               end
               ST_AFTER_ASSIGN: begin
                  raise = 1'b1;
                  code  = ERR_END_VALUE;
               end
               ST_TABLE_HEAD, ST_GROUP_OPEN: begin
                  raise = 1'b1;
                  code  = ERR_END_NEWLINE;
               end
               ST_ROW_START, ST_ROW_VALUES: begin
                  raise = 1'b1;
                  code  = ERR_END_TABLE;
               end
               default: begin
                  if ((view.count - DEPTH_W'(end_pop)) != '0) begin
                     raise = 1'b1;
                     code  = ERR_END_GROUP;
                  end else begin
                     res.action = ACT_ACCEPT;
                  end
               end
            endcase
         end
         op.clear = 1'b1;
         ctx_in   = CTX_RESET;
      end else if (ctx.fault_hold) begin
         // swallow tokens until end of text
      end else if (tok.scan_fault) begin
         raise = 1'b1;
         code  = ERR_SCAN;
      end else begin
         case (ctx.state)
            ST_LINE_START: begin
               if (tok.kind == KIND_NEWLINE) begin
               end else if (tok.kind == KIND_IDENT || tok.kind == KIND_TABLE_OPEN ||
                            tok.kind == KIND_GROUP_OPEN) begin
                  if (stack_full) begin
                     raise = 1'b1;
                     code  = ERR_STACK_OVF;
                  end else begin
                     op.push = 1'b1;
                     if (tok.kind == KIND_IDENT) begin
                        ctx_in.state = ST_AFTER_NAME;
                     end else if (tok.kind == KIND_GROUP_OPEN) begin
                        ctx_in.state = ST_GROUP_OPEN;
                     end else begin
                        ctx_in.state        = ST_TABLE_HEAD;
                        ctx_in.next_column  = '0;
                        ctx_in.column_total = '0;
                        ctx_in.row_total    = ROW_CNT_W'(1);
                        ctx_in.row_filled   = 1'b0;
                     end
                  end
               end else if (tok.kind == KIND_CLOSE) begin
                  if (stack_empty) begin
                     raise = 1'b1;
                     code  = ERR_UNMATCHED;
                  end else if (!top_match) begin
                     raise = 1'b1;
                     code  = ERR_MISMATCH;
                     oline = view.line;
                     ocol  = view.col;
                  end else begin
                     op.pop       = 1'b1;
                     ctx_in.state = ST_GROUP_CLOSED;
                  end
               end else begin
                  raise = 1'b1;
                  code  = ERR_BAD_TOKEN;
               end
            end
            ST_AFTER_NAME: begin
               if (tok.kind == KIND_ASSIGN) begin
                  ctx_in.state        = ST_AFTER_ASSIGN;
                  ctx_in.column_total = '0;
                  ctx_in.row_total    = ROW_CNT_W'(1);
               end else begin
                  raise = 1'b1;
                  code  = ERR_BAD_TOKEN;
               end
            end
            ST_AFTER_ASSIGN, ST_PARAM_VALUES: begin
               if (is_val) begin
                  if (ctx.column_total >= COLS_W'(MAX_COLUMNS)) begin
                     raise = 1'b1;
                     code  = ERR_TABLE_OVF;
                  end else begin
                     res.action          = ACT_STORED;
                     res.cell_col        = COL_IDX_W'(ctx.column_total);
                     ctx_in.column_total = ctx.column_total + COLS_W'(1);
                     ctx_in.state        = ST_PARAM_VALUES;
                  end
               end else if (tok.kind == KIND_NEWLINE && ctx.state == ST_PARAM_VALUES) begin
                  res.action    = ACT_PARAM_DONE;
                  res.item_rows = ROWS_W'(1);
                  res.item_cols = ctx.column_total;
                  op.pop        = !stack_empty;
                  ctx_in.state  = ST_LINE_START;
               end else begin
                  raise = 1'b1;
                  code  = ERR_BAD_TOKEN;
               end
            end
            ST_TABLE_HEAD: begin
               if (tok.kind == KIND_NEWLINE) begin
                  ctx_in.state = ST_ROW_START;
               end else begin
                  raise = 1'b1;
                  code  = ERR_BAD_TOKEN;
               end
            end
            ST_ROW_START, ST_ROW_VALUES: begin
               if (is_val) begin
                  if (ctx.next_column >= COLS_W'(MAX_COLUMNS) || ctx.row_total == '0 ||
                      ctx.row_total > ROW_CNT_W'(MAX_ROWS)) begin
                     raise = 1'b1;
                     code  = ERR_TABLE_OVF;
                  end else begin
                     res.action         = ACT_STORED;
                     res.cell_row       = ROW_IDX_W'(ctx.row_total - ROW_CNT_W'(1));
                     res.cell_col       = COL_IDX_W'(ctx.next_column);
                     ctx_in.next_column = col_next;
                     if (col_next > ctx.column_total) begin
                        ctx_in.column_total = col_next;
                     end
                     ctx_in.row_filled  = 1'b1;
                     ctx_in.state       = ST_ROW_VALUES;
                  end
               end else if (tok.kind == KIND_NEWLINE) begin
                  // empty rows do not advance the row count
                  if (ctx.state == ST_ROW_VALUES) begin
                     if (ctx.row_filled) begin
                        ctx_in.row_total = ctx.row_total + ROW_CNT_W'(1);
                     end
                     ctx_in.row_filled  = 1'b0;
                     ctx_in.next_column = '0;
                  end
               end else if (tok.kind == KIND_CLOSE) begin
                  if (stack_empty) begin
                     raise = 1'b1;
                     code  = ERR_UNMATCHED;
                  end else if (!top_match) begin
                     raise = 1'b1;
                     code  = ERR_MISMATCH;
                     oline = view.line;
                     ocol  = view.col;
                  end else begin
                     // the open last row is dropped
                     op.pop        = 1'b1;
                     res.action    = ACT_TABLE_DONE;
                     res.item_rows = (ctx.row_total != '0) ?
                                     ROWS_W'(ctx.row_total - ROW_CNT_W'(1)) : '0;
                     res.item_cols = ctx.column_total;
                     ctx_in.state  = ST_TABLE_CLOSED;
                  end
               end else begin
                  raise = 1'b1;
                  code  = ERR_BAD_TOKEN;
               end
            end
            ST_TABLE_CLOSED, ST_GROUP_OPEN, ST_GROUP_CLOSED: begin
               if (tok.kind == KIND_NEWLINE) begin
                  ctx_in.state = ST_LINE_START;
               end else begin
                  raise = 1'b1;
                  code  = ERR_BAD_TOKEN;
               end
            end
            default: begin
               raise = 1'b1;
               code  = ERR_BAD_TOKEN;
            end
         endcase
      end

      if (raise) begin
         res.action    = ACT_ERROR;
         res.err_code  = code;
         res.err_state = ctx.state;
         res.err_line  = tok.line;
         res.err_col   = tok.col;
         res.open_line = oline;
         res.open_col  = ocol;
         res.cell_row  = '0;
         res.cell_col  = '0;
         res.item_rows = '0;
         res.item_cols = '0;
         if (tok.kind != KIND_END) begin
            ctx_in.fault_hold = 1'b1;
         end
      end

      res.nest_depth = op.clear ? '0 :
                       view.count + DEPTH_W'(op.push) - DEPTH_W'(op.pop);
   end

endmodule

### design/config_token_syntax_checker.sv
// Top level: token input register, grammar step, stack and result register.
//
// Checks a stream of configuration-text tokens (parameter lines, tables and
// nested named groups) and returns exactly one result per token: a stored
// value cell, a completed parameter or table with its size, an error with its
// position, or acceptance at the end token. Tokens transfer one per cycle,
// back to back, while the result register is free or draining. A token's
// result goes through the input register, then the result register, where it
// waits for rsp_ready. The rate is set by the grammar step, which reads only
// the stack top and a few counters combinationally. After an error every
// token up to the end token gives action none; the end token restarts the
// checker. Nesting is limited to STACK_DEPTH open names.
module config_token_syntax_checker import cts_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [KIND_W-1:0]    req_token_kind,
   input  logic [TAG_W-1:0]     req_name_tag,
   input  logic [LINE_W-1:0]    req_token_line,
   input  logic [COL_W-1:0]     req_token_col,
   input  logic                 req_scan_fault,

   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [2:0]           rsp_action,
   output logic [3:0]           rsp_err_code,
   output logic [3:0]           rsp_err_state,
   output logic [LINE_W-1:0]    rsp_err_line,
   output logic [COL_W-1:0]     rsp_err_col,
   output logic [LINE_W-1:0]    rsp_open_line,
   output logic [COL_W-1:0]     rsp_open_col,
   output logic [ROW_IDX_W-1:0] rsp_cell_row,
   output logic [COL_IDX_W-1:0] rsp_cell_col,
   output logic [ROWS_W-1:0]    rsp_item_rows,
   output logic [COLS_W-1:0]    rsp_item_cols,
   output logic [DEPTH_W-1:0]   rsp_nest_depth
);

   token_type      tok_ff;
   token_type      tok_in;
   logic           tok_valid_ff;
   logic           tok_valid_in;
   ctx_type        ctx_ff;
   ctx_type        ctx_in;
   result_type     rsp_ff;
   result_type     rsp_in;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   logic           advance;
   logic           req_xfer;
   stack_op_type   step_op;
   stack_op_type   stk_op;
   stack_view_type view;

   // token moves into the result register when that register is free or draining
   assign advance   = tok_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !tok_valid_ff || advance;
   assign req_xfer  = req_valid && req_ready;

   assign tok_in.kind       = req_token_kind;
   assign tok_in.name_tag   = req_name_tag;
   assign tok_in.line       = req_token_line;
   assign tok_in.col        = req_token_col;
   assign tok_in.scan_fault = req_scan_fault;

   assign tok_valid_in = req_xfer || (tok_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   cts_grammar u_grammar (
      .tok    (tok_ff),
      .ctx    (ctx_ff),
      .view   (view),
      .ctx_in (ctx_in),
      .op     (step_op),
      .res    (rsp_in)
   );

   assign stk_op = advance ? step_op : '0;

   cts_stack u_stack (
      .clock (clock),
      .reset (reset),
      .op    (stk_op),
      .view  (view)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ctx_ff       <= CTX_RESET;
      end else begin
         tok_valid_ff <= tok_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            ctx_ff <= ctx_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         tok_ff <= tok_in;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_action     = rsp_ff.action;
   assign rsp_err_code   = rsp_ff.err_code;
   assign rsp_err_state  = rsp_ff.err_state;
   assign rsp_err_line   = rsp_ff.err_line;
   assign rsp_err_col    = rsp_ff.err_col;
   assign rsp_open_line  = rsp_ff.open_line;
   assign rsp_open_col   = rsp_ff.open_col;
   assign rsp_cell_row   = rsp_ff.cell_row;
   assign rsp_cell_col   = rsp_ff.cell_col;
   assign rsp_item_rows  = rsp_ff.item_rows;
   assign rsp_item_cols  = rsp_ff.item_cols;
   assign rsp_nest_depth = rsp_ff.nest_depth;

`ifndef SYNTH
   a_end_empties_stack: assert property (@(posedge clock) disable iff (reset)
      advance && tok_ff.kind == KIND_END |=> rsp_nest_depth == '0 && view.count == '0)
      else $error("end token left open names on the stack");

   a_depth_tracks_stack: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_nest_depth == view.count)
      else $error("reported depth differs from stack count");

   a_error_sets_hold: assert property (@(posedge clock) disable iff (reset)
      advance && rsp_in.action == ACT_ERROR && tok_ff.kind != KIND_END |=> ctx_ff.fault_hold)
      else $error("error transfer did not arm the error hold");

   a_code_only_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_ff.action == ACT_ERROR) == (rsp_ff.err_code != ERR_NONE)))
      else $error("error code and action disagree");

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      view.count <= DEPTH_W'(STACK_DEPTH))
      else $error("stack count beyond depth");
`endif

endmodule
